[rtl/core/cbht_pkg.sv]
// Package for the CBOR item head tokenizer: event codes, parse phases,
// additional-info constants and the result record. No dependencies.
package cbht_pkg;

  localparam int unsigned ArgW = 64;

  typedef enum logic [1:0] {
    EV_HEAD    = 2'd0,
    EV_PAYLOAD = 2'd1,
    EV_ERROR   = 2'd2
  } event_kind_e;

  typedef enum logic [1:0] {
    PH_INITIAL = 2'd0,
    PH_ARG     = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  // additional info codes
  localparam logic [4:0] AI_MASK = 5'h1F;
  localparam logic [4:0] AI_ARG1 = 5'd24;
  localparam logic [4:0] AI_ARG2 = 5'd25;
  localparam logic [4:0] AI_ARG4 = 5'd26;
  localparam logic [4:0] AI_ARG8 = 5'd27;

  // string major types
  localparam logic [2:0] MAJOR_BSTR = 3'd2;
  localparam logic [2:0] MAJOR_TSTR = 3'd3;

  typedef struct packed {
    event_kind_e       kind;
    logic [2:0]        major;
    logic [ArgW-1:0]   argument;
    logic [7:0]        pbyte;
    logic              last;
  } cbht_result_t;

endpackage

[rtl/core/cbor_head_tokenizer.sv]
// CBOR item head tokenizer: one byte in per cycle while not stalled, at most one event out.
// Depends on cbht_pkg.
//
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------
//  in      | in_valid_i / in_stall_o    | data_byte_i, resync_i
//  out     | out_valid_o / out_stall_i  | event_kind_o, major_type_o,
//          |                            | argument_o, payload_byte_o,
//          |                            | last_payload_o
//  cfg     | cfg_valid_i / cfg_ready_o  | cfg_data_i (string_payload_mode)
//
// One byte per cycle while in_stall_o is low; its event is registered in the
// main entry, or in the skid entry while the main one stalls. Parse state
// updates in the cycle the byte is taken. The output stage is a main register
// plus a skid entry; in_stall_o is the skid flag alone, so it never depends
// combinationally on out_stall_i. Reset (rst_ni low, async) clears phase and output valids, sets mode to 1.
module cbor_head_tokenizer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // byte stream
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  resync_i,
  // events
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output cbht_pkg::event_kind_e event_kind_o,
  output logic [2:0]            major_type_o,
  output logic [63:0]           argument_o,
  output logic [7:0]            payload_byte_o,
  output logic                  last_payload_o,
  // configuration
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_data_i
);
  import cbht_pkg::*;

  // ---------------------------------------------------------------------
  // Parse state
  // ---------------------------------------------------------------------
  logic            mode_q;
  phase_e          phase_q, phase_d;
  logic [3:0]      arg_left_q, arg_left_d;
  logic [ArgW-1:0] acc_q, acc_d;
  logic [2:0]      held_major_q, held_major_d;
  logic [ArgW-1:0] payload_left_q, payload_left_d;

  logic            in_xfer;
  logic            res_vld;
  cbht_result_t    res;

  assign cfg_ready_o = 1'b1;
  assign in_xfer     = in_valid_i && !in_stall_o;

  always_comb begin
    phase_e          cur;
    logic [2:0]      b_major;
    logic [4:0]      b_ai;
    logic [3:0]      left_dec;
    logic [ArgW-1:0] acc_shift;
    logic [ArgW-1:0] rest;
    logic            head_done;
    logic [2:0]      head_major;
    logic [ArgW-1:0] head_arg;

    phase_d        = phase_q;
    arg_left_d     = arg_left_q;
    acc_d          = acc_q;
    held_major_d   = held_major_q;
    payload_left_d = payload_left_q;
    res_vld        = 1'b0;
    res            = '{kind: EV_HEAD, major: '0, argument: '0, pbyte: '0, last: 1'b0};
    head_done      = 1'b0;
    head_major     = '0;
    head_arg       = '0;

    // resync drops any partial head or payload before this byte
    cur = resync_i ? PH_INITIAL : phase_q;
    if (resync_i) begin
      arg_left_d     = '0;
      acc_d          = '0;
      payload_left_d = '0;
    end

    b_major   = data_byte_i[7:5];
    b_ai      = data_byte_i[4:0] & AI_MASK;
    left_dec  = arg_left_q - 4'd1;
    acc_shift = {acc_q[ArgW-9:0], data_byte_i};
    rest      = payload_left_q - {{(ArgW-1){1'b0}}, 1'b1};

    unique case (cur)
      PH_ARG: begin
        acc_d      = acc_shift;
        arg_left_d = left_dec;
        if (left_dec == 4'd0) begin
          head_done  = 1'b1;
          head_major = held_major_q;
          head_arg   = acc_shift;
        end
      end
      PH_PAYLOAD: begin
        res_vld        = 1'b1;
        res.kind       = EV_PAYLOAD;
        res.major      = held_major_q;
        res.argument   = rest;
        res.pbyte      = data_byte_i;
        res.last       = (rest == '0);
        payload_left_d = rest;
        if (rest == '0) phase_d = PH_INITIAL;
      end
      default: begin
        // initial byte, also for the unused phase code
        phase_d = PH_INITIAL;
        if (b_ai < AI_ARG1) begin
          head_done  = 1'b1;
          head_major = b_major;
          head_arg   = {{(ArgW-5){1'b0}}, b_ai};
        end else if (b_ai <= AI_ARG8) begin
          // 24..27 -> 1, 2, 4, 8 argument bytes
          held_major_d = b_major;
          acc_d        = '0;
          arg_left_d   = 4'd1 << b_ai[1:0];
          phase_d      = PH_ARG;
        end else begin
          res_vld      = 1'b1;
          res.kind     = EV_ERROR;
          res.major    = b_major;
          res.argument = {{(ArgW-5){1'b0}}, b_ai};
        end
      end
    endcase

    if (head_done) begin
      res_vld      = 1'b1;
      res.kind     = EV_HEAD;
      res.major    = head_major;
      res.argument = head_arg;
      held_major_d = head_major;
      // mode is sampled here; a running string finishes regardless
      if (mode_q && (head_major == MAJOR_BSTR || head_major == MAJOR_TSTR)
          && head_arg != '0) begin
        payload_left_d = head_arg;
        phase_d        = PH_PAYLOAD;
      end else begin
        payload_left_d = '0;
        phase_d        = PH_INITIAL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= 1'b1;
      phase_q        <= PH_INITIAL;
      arg_left_q     <= '0;
      acc_q          <= '0;
      held_major_q   <= '0;
      payload_left_q <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) mode_q <= cfg_data_i;
      if (in_xfer) begin
        phase_q        <= phase_d;
        arg_left_q     <= arg_left_d;
        acc_q          <= acc_d;
        held_major_q   <= held_major_d;
        payload_left_q <= payload_left_d;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output stage: main register plus skid entry
  // ---------------------------------------------------------------------
  logic         out_vld_q, out_vld_d;
  logic         skid_vld_q, skid_vld_d;
  cbht_result_t out_q, out_d;
  cbht_result_t skid_q, skid_d;
  logic         out_xfer;
  logic         new_res;

  assign in_stall_o = skid_vld_q;
  assign out_xfer   = out_vld_q && !out_stall_i;
  assign new_res    = in_xfer && res_vld;

  always_comb begin
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    skid_vld_d = skid_vld_q;
    skid_d     = skid_q;
    if (out_xfer || !out_vld_q) begin
      if (skid_vld_q) begin
        out_vld_d  = 1'b1;
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end else begin
        out_vld_d = new_res;
        out_d     = res;
      end
    end else if (new_res) begin
      // main entry stalled: park the new event
      skid_vld_d = 1'b1;
      skid_d     = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o    = out_vld_q;
  assign event_kind_o   = out_q.kind;
  assign major_type_o   = out_q.major;
  assign argument_o     = out_q.argument;
  assign payload_byte_o = out_q.pbyte;
  assign last_payload_o = out_q.last;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry holds an event while the main entry is empty");

  a_payload_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> payload_left_q != '0)
    else $error("payload phase with no bytes left");

  a_arg_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_ARG |-> arg_left_q != 4'd0)
    else $error("argument phase with no bytes left");

  a_last_marks_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.last |-> out_q.kind == EV_PAYLOAD && out_q.argument == '0)
    else $error("last payload flag on a non-final event");

endmodule

[tb/cbht_event_checker.sv]
`timescale 1ns / 1ps
// Event checker for the CBOR head tokenizer: watches the byte, event and config
// channels, predicts each event and compares it field by field. Uses cbht_pkg.
module cbht_event_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  resync_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  cbht_pkg::event_kind_e event_kind_i,
  input  logic [2:0]            major_type_i,
  input  logic [63:0]           argument_i,
  input  logic [7:0]            payload_byte_i,
  input  logic                  last_payload_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic                  cfg_data_i,
  output int                    mismatches_o,
  output int                    outstanding_o
);
  import cbht_pkg::*;

  // shadow parse state
  logic         payload_mode;
  phase_e       parse_phase;
  logic [3:0]   arg_left;
  logic [63:0]  arg_acc;
  logic [2:0]   held_major;
  logic [63:0]  payload_left;

  cbht_result_t expected_events[$];
  int           err_total;

  function automatic cbht_result_t close_head(input logic [2:0] major, input logic [63:0] arg);
    cbht_result_t ev;
    ev          = '0;
    ev.kind     = EV_HEAD;
    ev.major    = major;
    ev.argument = arg;
    held_major  = major;
    if (payload_mode && (major == MAJOR_BSTR || major == MAJOR_TSTR) && arg != '0) begin
      payload_left = arg;
      parse_phase  = PH_PAYLOAD;
    end else begin
      payload_left = '0;
      parse_phase  = PH_INITIAL;
    end
    return ev;
  endfunction

  // Advance the shadow state by one byte; returns 1 when the byte yields an event.
  function automatic logic tokenize_byte(input logic [7:0] b, input logic rs,
                                         output cbht_result_t ev);
    logic [63:0] rest;
    logic [2:0]  major;
    logic [4:0]  ai;
    ev = '0;
    if (rs) begin
      parse_phase  = PH_INITIAL;
      arg_left     = '0;
      arg_acc      = '0;
      payload_left = '0;
    end
    if (parse_phase == PH_ARG) begin
      arg_acc  = {arg_acc[55:0], b};
      arg_left = arg_left - 4'd1;
      if (arg_left != '0) return 1'b0;
      ev = close_head(held_major, arg_acc);
      return 1'b1;
    end
    if (parse_phase == PH_PAYLOAD) begin
      rest         = payload_left - 64'd1;
      ev.kind      = EV_PAYLOAD;
      ev.major     = held_major;
      ev.argument  = rest;
      ev.pbyte     = b;
      ev.last      = (rest == '0);
      payload_left = rest;
      if (rest == '0) parse_phase = PH_INITIAL;
      return 1'b1;
    end
    // initial byte; an unused phase code lands here too
    parse_phase = PH_INITIAL;
    major       = b[7:5];
    ai          = b[4:0];
    if (ai < AI_ARG1) begin
      ev = close_head(major, {59'd0, ai});
      return 1'b1;
    end
    if (ai <= AI_ARG8) begin
      held_major  = major;
      arg_acc     = '0;
      arg_left    = 4'd1 << (ai - AI_ARG1);
      parse_phase = PH_ARG;
      return 1'b0;
    end
    ev.kind     = EV_ERROR;
    ev.major    = major;
    ev.argument = {59'd0, ai};
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    cbht_result_t ev;
    cbht_result_t want;
    if (!rst_ni) begin
      payload_mode  = 1'b1;
      parse_phase   = PH_INITIAL;
      arg_left      = '0;
      arg_acc       = '0;
      held_major    = '0;
      payload_left  = '0;
      err_total     = 0;
      expected_events.delete();
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) payload_mode = cfg_data_i;
      if (in_valid_i && !in_stall_i) begin
        if (tokenize_byte(data_byte_i, resync_i, ev)) expected_events.push_back(ev);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_events.size() == 0) begin
          $error("unexpected event: kind %0d major %0d argument %0h",
                 event_kind_i, major_type_i, argument_i);
          err_total++;
        end else begin
          want = expected_events.pop_front();
          if (event_kind_i !== want.kind) begin
            $error("event_kind: expected %0d, got %0d", want.kind, event_kind_i);
            err_total++;
          end
          if (major_type_i !== want.major) begin
            $error("major_type: expected %0d, got %0d", want.major, major_type_i);
            err_total++;
          end
          if (argument_i !== want.argument) begin
            $error("argument: expected %0h, got %0h", want.argument, argument_i);
            err_total++;
          end
          if (payload_byte_i !== want.pbyte) begin
            $error("payload_byte: expected %0h, got %0h", want.pbyte, payload_byte_i);
            err_total++;
          end
          if (last_payload_i !== want.last) begin
            $error("last_payload: expected %0b, got %0b", want.last, last_payload_i);
            err_total++;
          end
        end
      end
      mismatches_o  <= err_total;
      outstanding_o <= expected_events.size();
    end
  end

endmodule

[tb/tb_cbor_head_tokenizer.sv]
`timescale 1ns / 1ps
// Top of the CBOR head tokenizer testbench: clock, reset, byte stream stimulus,
// event-side stall pattern and verdict. Uses cbht_pkg and cbht_event_checker.
module tb_cbor_head_tokenizer;
  import cbht_pkg::*;

  localparam int CycleLimit  = 600000;
  localparam int PhaseItems  = 400;  // bytes per random phase, four phases
  localparam int LongHold    = 300;  // receiver hold-off, long enough to back up the input
  localparam int TailCycles  = 8;

  logic        clk_i;
  logic        rst_n;

  // byte stream
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        resync;

  // events
  logic        out_valid;
  logic        out_stall;
  event_kind_e event_kind;
  logic [2:0]  major_type;
  logic [63:0] argument;
  logic [7:0]  payload_byte;
  logic        last_payload;

  // config
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  int          mismatches;
  int          outstanding;

  // knobs shared between the stimulus and stall processes
  int          idle_odds;       // 1-in-N idle burst odds (1-in-2N for stalls), 0 = none
  logic        quiet_tail;      // end of run: no idling on either side
  logic        long_hold_req;   // ask the receiver for one long hold-off
  logic        resync_next;     // next byte carries resync
  logic        random_resync;   // sprinkle resync over random bytes
  int          byte_count;

  cbor_head_tokenizer DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .data_byte_i    (data_byte),
    .resync_i       (resync),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .event_kind_o   (event_kind),
    .major_type_o   (major_type),
    .argument_o     (argument),
    .payload_byte_o (payload_byte),
    .last_payload_o (last_payload),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  cbht_event_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .data_byte_i    (data_byte),
    .resync_i       (resync),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .event_kind_i   (event_kind),
    .major_type_i   (major_type),
    .argument_i     (argument),
    .payload_byte_i (payload_byte),
    .last_payload_i (last_payload),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CycleLimit) begin
        $display("[cbor_head_tokenizer] ERROR");
        $finish;
      end
    end
  end

  // Event-side stall pattern. Random stall bursts, plus one long hold-off on
  // request while the sender keeps going, so the two-entry output stage fills
  // and in_stall has to rise.
  initial begin : receiver
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        long_hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (!quiet_tail && idle_odds != 0 && $urandom_range(1, 2 * idle_odds) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one byte and return at the edge where it transfers. An idle burst may
  // come first; besides the drains, valid is only dropped here, so it never toggles within a step.
  task automatic push_byte(input logic [7:0] b);
    logic rs;
    if (!quiet_tail && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    rs          = resync_next || (random_resync && $urandom_range(0, 79) == 0);
    resync_next = 1'b0;
    in_valid  <= 1'b1;
    data_byte <= b;
    resync    <= rs;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    byte_count++;
  endtask

  // Initial byte plus its big-endian argument bytes; the last 'drop' argument
  // bytes are left off to build truncated heads.
  task automatic push_head(input logic [2:0] major, input logic [4:0] ai,
                           input logic [63:0] value, input int drop);
    int n;
    n = 0;
    push_byte({major, ai});
    if (ai >= AI_ARG1 && ai <= AI_ARG8) n = 1 << (ai - AI_ARG1);
    for (int i = n - 1; i >= drop; i--) push_byte(value[8*i +: 8]);
  endtask

  // Stop offering and wait until every predicted event has been seen. The extra
  // wait at the end covers bytes that produce no event but still move the DUT state.
  task automatic drain_events();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_payload_mode(input logic mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // A well-formed data item: a head with random width, and for string majors
  // a short payload. Lengths are mostly small so strings finish quickly.
  task automatic send_item();
    logic [2:0]  major;
    logic [4:0]  ai;
    logic [63:0] value;
    int          w;
    int          len;
    major = 3'($urandom_range(0, 7));
    w     = $urandom_range(0, 4);
    if (major == MAJOR_BSTR || major == MAJOR_TSTR) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      if (len >= 24 && w == 0) w = 1;
      ai = (w == 0) ? 5'(len) : 5'(AI_ARG1 + w - 1);
      push_head(major, ai, 64'(len), 0);
      // with the mode off these bytes are parsed as heads, which is fine noise
      for (int i = 0; i < len; i++) push_byte(8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 7))
        0:       value = '0;
        1:       value = '1;
        default: value = {$urandom, $urandom};
      endcase
      ai = (w == 0) ? 5'($urandom_range(0, 23)) : 5'(AI_ARG1 + w - 1);
      push_head(major, ai, value, 0);
    end
  endtask

  // Malformed input: cut-off argument, cut-off string, or raw noise. Each is
  // followed by a resync so a stray huge length cannot swallow the stream.
  task automatic send_broken();
    logic [2:0] major;
    logic [4:0] ai;
    int         n;
    int         len;
    case ($urandom_range(0, 2))
      0: begin
        ai = 5'($urandom_range(AI_ARG2, AI_ARG8));
        n  = 1 << (ai - AI_ARG1);
        push_head(3'($urandom_range(0, 7)), ai, {$urandom, $urandom}, $urandom_range(1, n - 1));
      end
      1: begin
        major = ($urandom_range(0, 1) == 0) ? MAJOR_BSTR : MAJOR_TSTR;
        len   = $urandom_range(2, 12);
        push_head(major, 5'(len), 64'(len), 0);
        repeat ($urandom_range(0, len - 1)) push_byte(8'($urandom_range(0, 255)));
      end
      default: begin
        repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
      end
    endcase
    resync_next = 1'b1;
  endtask

  initial begin : stimulus
    int   phase_start;
    int   done_in_phase;
    logic held;
    logic paused;

    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    data_byte     <= '0;
    resync        <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_data      <= 1'b0;
    idle_odds     = 0;
    quiet_tail    = 1'b0;
    long_hold_req = 1'b0;
    resync_next   = 1'b0;
    random_resync = 1'b0;
    byte_count    = 0;

    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // ---- directed part, payload mode at its reset value of 1 ----
    idle_odds = 6;
    push_byte(8'h00);                            // smallest head
    push_byte(8'hFF);                            // major 7, reserved info 31
    push_byte({3'd1, AI_ARG8 + 5'd1});           // first indefinite/reserved code
    push_head(3'd0, AI_ARG8, '1, 0);             // eight argument bytes, largest value
    push_head(MAJOR_BSTR, 5'd0, '0, 0);          // zero-length string: no payload follows
    push_head(MAJOR_TSTR, 5'd2, 64'd2, 0);       // text string with extreme payload bytes
    push_byte(8'h00);
    push_byte(8'hFF);
    push_head(3'd1, AI_ARG2, 64'h1234, 1);       // argument cut short...
    resync_next = 1'b1;
    push_byte(8'h01);                            // ...and dropped by resync
    // mode flipped while a string is in its payload: the string still finishes
    push_head(MAJOR_BSTR, 5'd5, 64'd5, 0);
    push_byte(8'h78);
    push_byte(8'h79);
    drain_events();
    write_payload_mode(1'b0);
    push_byte(8'h7A);
    push_byte(8'h77);
    push_byte(8'h76);
    // mode off: the string head is emitted, the next byte is a head again
    push_head(MAJOR_BSTR, 5'd2, 64'd2, 0);
    push_byte(8'h01);
    drain_events();

    // ---- random part: four phases over both mode values ----
    random_resync = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      write_payload_mode(ph == 1 ? 1'b0 : 1'b1);
      resync_next = 1'b1;
      case (ph)
        0:       idle_odds = 10;
        1:       idle_odds = 0;   // a stretch with no idling at all
        2:       idle_odds = 3;   // heavy idling on both sides
        default: idle_odds = 8;
      endcase
      phase_start = byte_count;
      held        = 1'b0;
      paused      = 1'b0;
      done_in_phase = 0;
      while (done_in_phase < PhaseItems) begin
        if (ph == 0 && !held && done_in_phase >= 100) begin
          long_hold_req = 1'b1;
          held          = 1'b1;
        end
        if (ph == 0 && !paused && done_in_phase >= 250) begin
          // sender waits for every outstanding event before going on
          drain_events();
          paused = 1'b1;
        end
        if (ph == 3 && done_in_phase >= PhaseItems / 3) quiet_tail = 1'b1;
        case ($urandom_range(0, 99)) inside
          [0:69]:  send_item();
          [70:79]: push_byte({3'($urandom_range(0, 7)),
                              5'($urandom_range(AI_ARG8 + 1, AI_MASK))});
          default: send_broken();
        endcase
        done_in_phase = byte_count - phase_start;
      end
      drain_events();
    end

    // ---- end of run ----
    in_valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[cbor_head_tokenizer] OK");
    end else begin
      $display("[cbor_head_tokenizer] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/cbht_pkg.sv
rtl/core/cbor_head_tokenizer.sv
tb/cbht_event_checker.sv
tb/tb_cbor_head_tokenizer.sv
